@@ src/pfba_pkg.sv @@
// shared types and constants of the page frame bitmap allocator
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int ADDR_W     = 32;
   localparam int KIND_W     = 8;
   localparam int PAGES_W    = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int PAGE_SHIFT = 12;
   localparam int PN_W       = ADDR_W - PAGE_SHIFT;
   localparam int OFS_W      = PN_W + 1;
   localparam int WORD_W     = 32;
   localparam int NREG       = 2;

   // number of page frames below the top of the address space
   localparam logic [OFS_W-1:0] PAGE_SPAN = OFS_W'(1) << PN_W;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PAGE  = 2'd0,
      OP_RANGE = 2'd1,
      OP_ALLOC = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE0  = 3'd0,
      CSR_PAGES0 = 3'd1,
      CSR_KIND0  = 3'd2,
      CSR_BASE1  = 3'd3,
      CSR_PAGES1 = 3'd4,
      CSR_KIND1  = 3'd5
   } csr_type;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LIVE,
      ST_BOUND,
      ST_PLAN,
      ST_SEL,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic take_req;
      logic live;
      logic bound;
      logic plan;
      logic sel;
      logic rd;
      logic modify;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic pend_any;
      logic last_word;
      logic alloc;
      logic found;
   } status_type;

endpackage

`default_nettype wire

@@ src/pfba_if.sv @@
// request and response channel interfaces of the page frame bitmap allocator
`timescale 1ns / 1ps
`default_nettype none

interface pfba_req_if import pfba_pkg::*;;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] end_addr;
   logic              mark_used;
   logic [KIND_W-1:0] mem_type;

   modport source (output valid, op, addr, end_addr, mark_used, mem_type, input ready);
   modport sink (input valid, op, addr, end_addr, mark_used, mem_type, output ready);
endinterface

interface pfba_rsp_if import pfba_pkg::*;;
   logic              valid;
   logic              ready;
   logic              failed;
   logic [ADDR_W-1:0] page_addr;

   modport source (output valid, failed, page_addr, input ready);
   modport sink (input valid, failed, page_addr, output ready);
endinterface

`default_nettype wire

@@ src/pfba_ctrl.sv @@
// sequencing state machine of the page frame bitmap allocator
`timescale 1ns / 1ps
`default_nettype none

module pfba_ctrl import pfba_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LIVE;
         end
         ST_LIVE:  state_in = ST_BOUND;
         ST_BOUND: state_in = ST_PLAN;
         ST_PLAN:  state_in = ST_SEL;
         ST_SEL: begin
            state_in = status.pend_any ? ST_READ : ST_DONE;
         end
         ST_READ: state_in = ST_MODIFY;
         ST_MODIFY: begin
            if (status.alloc && status.found) state_in = ST_DONE;
            else if (status.last_word) state_in = ST_SEL;
            else state_in = ST_READ;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         ST_LIVE:   cmd.live = 1'b1;
         ST_BOUND:  cmd.bound = 1'b1;
         ST_PLAN:   cmd.plan = 1'b1;
         ST_SEL:    cmd.sel = status.pend_any;
         ST_READ:   cmd.rd = 1'b1;
         ST_MODIFY: cmd.modify = 1'b1;
         ST_DONE:   cmd.out_load = !rsp_valid_ff || rsp_ready;
         default:   cmd = '0;
      endcase
   end

   // response word valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ src/pfba_dp.sv @@
// datapath of the page frame bitmap allocator: region registers, bitmap memory, walk logic
`timescale 1ns / 1ps
`default_nettype none

module pfba_dp import pfba_pkg::*; #(
   parameter int MAX_PAGES   = 1024,
   parameter int NUM_REGIONS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   input  logic [OP_W-1:0]      req_op,
   input  logic [ADDR_W-1:0]    req_addr,
   input  logic [ADDR_W-1:0]    req_end_addr,
   input  logic                 req_mark_used,
   input  logic [KIND_W-1:0]    req_mem_type,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_failed,
   output logic [ADDR_W-1:0]    rsp_page_addr
);

   localparam int  WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
   localparam int  WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int  IW    = $clog2(MAX_PAGES);
   localparam int  NW    = $clog2(MAX_PAGES + 1);
   localparam int  MAW   = (NUM_REGIONS > 1) ? WAW + 1 : WAW;
   localparam int  DEPTH = 2 ** MAW;
   localparam bit  TWO   = (NUM_REGIONS > 1);

   // word of a page index inside its region
   function automatic logic [WAW-1:0] word_of(input logic [IW-1:0] idx);
      word_of = WAW'(idx >> 5);
   endfunction

   // bits of word w that fall into the index span [lo, hi], page 0 at the msb
   function automatic logic [WORD_W-1:0] span_mask(input logic [IW-1:0] lo,
                                                   input logic [IW-1:0] hi,
                                                   input logic [WAW-1:0] w);
      logic [WORD_W-1:0] ml;
      logic [WORD_W-1:0] mh;
      logic [WAW-1:0]    lw;
      logic [WAW-1:0]    hw;
      lw = word_of(lo);
      hw = word_of(hi);
      if (w == lw) ml = {WORD_W{1'b1}} >> lo[4:0];
      else if (w > lw) ml = {WORD_W{1'b1}};
      else ml = '0;
      if (w == hw) mh = {WORD_W{1'b1}} << (5'd31 - hi[4:0]);
      else if (w < hw) mh = {WORD_W{1'b1}};
      else mh = '0;
      span_mask = ml & mh;
   endfunction

   // configuration
   logic [PN_W-1:0]    base_ff  [NREG];
   logic [PN_W-1:0]    base_in  [NREG];
   logic [PAGES_W-1:0] pages_ff [NREG];
   logic [PAGES_W-1:0] pages_in [NREG];
   logic [KIND_W-1:0]  kind_ff  [NREG];
   logic [KIND_W-1:0]  kind_in  [NREG];

   // captured request
   op_type            op_ff, op_in;
   logic [PN_W-1:0]   s_pn_ff, s_pn_in;
   logic [PN_W-1:0]   e_pn_ff, e_pn_in;
   logic              aligned_ff, aligned_in;
   logic              gt_ff, gt_in;
   logic              mark_ff, mark_in;
   logic [KIND_W-1:0] want_ff, want_in;

   // live region bounds
   logic [PN_W-1:0]  b_ff [NREG];
   logic [PN_W-1:0]  b_in [NREG];
   logic [NW-1:0]    n_ff [NREG];
   logic [NW-1:0]    n_in [NREG];
   logic [OFS_W-1:0] room_c [NREG];
   logic [OFS_W-1:0] cap_c  [NREG];
   logic [PN_W-1:0]  last_c [NREG];

   // absolute page spans
   logic [PN_W-1:0] lo_abs_ff [NREG];
   logic [PN_W-1:0] lo_abs_in [NREG];
   logic [PN_W-1:0] hi_abs_ff [NREG];
   logic [PN_W-1:0] hi_abs_in [NREG];
   logic [PN_W-1:0] xlo_abs_ff, xlo_abs_in;
   logic [PN_W-1:0] xhi_abs_ff, xhi_abs_in;

   // walk plan
   logic [IW-1:0]   lo_ff [NREG];
   logic [IW-1:0]   lo_in [NREG];
   logic [IW-1:0]   hi_ff [NREG];
   logic [IW-1:0]   hi_in [NREG];
   logic [IW-1:0]   xlo_ff, xlo_in;
   logic [IW-1:0]   xhi_ff, xhi_in;
   logic            xv_ff, xv_in;
   logic [NREG-1:0] pend_ff, pend_in;
   logic [NREG-1:0] act_c;
   logic [NREG-1:0] present_c;
   logic            fail_ff, fail_in;
   logic            walk_ok_c;

   // walk position
   logic            cur_ff, cur_in;
   logic            cur_sel_c;
   logic [WAW-1:0]  w_ff, w_in;
   logic [MAW-1:0]  walk_addr;
   logic [MAW-1:0]  clr_ff, clr_in;

   // bitmap memory
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;
   logic              mem_we;
   logic [MAW-1:0]    mem_wa;
   logic [WORD_W-1:0] mem_wd;

   // word update
   logic [WORD_W-1:0] mask_c;
   logic [WORD_W-1:0] excl_c;
   logic [WORD_W-1:0] new_c;
   logic [4:0]        pos_c;
   logic              is_alloc;
   logic              found_c;

   // result
   logic [ADDR_W-1:0] page_ff, page_in;
   logic              out_failed_ff, out_failed_in;
   logic [ADDR_W-1:0] out_page_ff, out_page_in;

   // configuration writes
   always_comb begin
      base_in  = base_ff;
      pages_in = pages_ff;
      kind_in  = kind_ff;
      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_BASE0:  base_in[0]  = csr_wdata[ADDR_W-1:PAGE_SHIFT];
            CSR_PAGES0: pages_in[0] = csr_wdata[PAGES_W-1:0];
            CSR_KIND0:  kind_in[0]  = csr_wdata[KIND_W-1:0];
            CSR_BASE1:  base_in[1]  = csr_wdata[ADDR_W-1:PAGE_SHIFT];
            CSR_PAGES1: pages_in[1] = csr_wdata[PAGES_W-1:0];
            CSR_KIND1:  kind_in[1]  = csr_wdata[KIND_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture; a single page is a one-page span
   always_comb begin
      op_in      = op_ff;
      s_pn_in    = s_pn_ff;
      e_pn_in    = e_pn_ff;
      aligned_in = aligned_ff;
      gt_in      = gt_ff;
      mark_in    = mark_ff;
      want_in    = want_ff;
      if (cmd.take_req) begin
         op_in      = op_type'(req_op);
         s_pn_in    = req_addr[ADDR_W-1:PAGE_SHIFT];
         e_pn_in    = (op_type'(req_op) == OP_PAGE) ? req_addr[ADDR_W-1:PAGE_SHIFT]
                                                    : req_end_addr[ADDR_W-1:PAGE_SHIFT];
         aligned_in = (req_addr[PAGE_SHIFT-1:0] == '0);
         gt_in      = (req_addr > req_end_addr);
         mark_in    = req_mark_used;
         want_in    = req_mem_type;
      end
   end

   // live region size: clamp to the bitmap and to the top of memory
   always_comb begin
      for (int r = 0; r < NREG; r++) begin
         room_c[r] = PAGE_SPAN - OFS_W'(base_ff[r]);
         cap_c[r]  = (OFS_W'(pages_ff[r]) > OFS_W'(MAX_PAGES)) ? OFS_W'(MAX_PAGES)
                                                              : OFS_W'(pages_ff[r]);
         b_in[r]   = cmd.live ? base_ff[r] : b_ff[r];
         n_in[r]   = n_ff[r];
         if (cmd.live) n_in[r] = (cap_c[r] > room_c[r]) ? NW'(room_c[r]) : NW'(cap_c[r]);
      end
   end

   // clip the request span to each region, and region 0 to region 1
   always_comb begin
      for (int r = 0; r < NREG; r++) begin
         last_c[r]    = PN_W'(OFS_W'(b_ff[r]) + OFS_W'(n_ff[r]) - OFS_W'(1));
         lo_abs_in[r] = lo_abs_ff[r];
         hi_abs_in[r] = hi_abs_ff[r];
         if (cmd.bound) begin
            lo_abs_in[r] = (s_pn_ff > b_ff[r]) ? s_pn_ff : b_ff[r];
            hi_abs_in[r] = (e_pn_ff < last_c[r]) ? e_pn_ff : last_c[r];
         end
      end
      xlo_abs_in = xlo_abs_ff;
      xhi_abs_in = xhi_abs_ff;
      if (cmd.bound) begin
         xlo_abs_in = (b_ff[0] > b_ff[1]) ? b_ff[0] : b_ff[1];
         xhi_abs_in = (last_c[0] < last_c[1]) ? last_c[0] : last_c[1];
      end
   end

   // walk plan in region-relative page indexes
   always_comb begin
      is_alloc  = (op_ff == OP_ALLOC);
      walk_ok_c = aligned_ff && ((op_ff == OP_PAGE) || ((op_ff == OP_RANGE) && !gt_ff));
      for (int r = 0; r < NREG; r++) begin
         present_c[r] = (n_ff[r] != '0) && ((r == 0) || TWO);
         if (is_alloc)
            act_c[r] = present_c[r] && (kind_ff[r] == want_ff) && (n_ff[r][NW-1:5] != '0);
         else
            act_c[r] = walk_ok_c && present_c[r] && (lo_abs_ff[r] <= hi_abs_ff[r]);
         lo_in[r] = lo_ff[r];
         hi_in[r] = hi_ff[r];
         if (cmd.plan) begin
            lo_in[r] = is_alloc ? '0 : IW'(lo_abs_ff[r] - b_ff[r]);
            hi_in[r] = is_alloc ? IW'({n_ff[r][NW-1:5], 5'd0} - NW'(1))
                                : IW'(hi_abs_ff[r] - b_ff[r]);
         end
      end
      xv_in  = xv_ff;
      xlo_in = xlo_ff;
      xhi_in = xhi_ff;
      fail_in = fail_ff;
      if (cmd.plan) begin
         xv_in  = present_c[0] && present_c[1] && (xlo_abs_ff <= xhi_abs_ff);
         xlo_in = IW'(xlo_abs_ff - b_ff[1]);
         xhi_in = IW'(xhi_abs_ff - b_ff[1]);
         case (op_ff)
            OP_PAGE:  fail_in = !(walk_ok_c && (act_c != '0));
            OP_RANGE: fail_in = gt_ff;
            OP_ALLOC: fail_in = 1'b0;
            default:  fail_in = 1'b1;
         endcase
      end
   end

   // region selection and word counter
   always_comb begin
      cur_sel_c = !pend_ff[0];
      pend_in   = pend_ff;
      cur_in    = cur_ff;
      w_in      = w_ff;
      if (cmd.plan) pend_in = act_c;
      if (cmd.sel) begin
         pend_in[cur_sel_c] = 1'b0;
         cur_in             = cur_sel_c;
         w_in               = word_of(lo_ff[cur_sel_c]);
      end else if (cmd.modify) begin
         w_in = w_ff + 1'b1;
      end
   end

   assign walk_addr = MAW'({cur_ff, w_ff});
   assign clr_in    = cmd.clear ? clr_ff + 1'b1 : clr_ff;

   // word update: span mark or release, or first free page for allocation
   always_comb begin
      mask_c = span_mask(lo_ff[cur_ff], hi_ff[cur_ff], w_ff);
      excl_c = (xv_ff && cur_ff) ? span_mask(xlo_ff, xhi_ff, w_ff) : '0;
      pos_c  = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (!rd_ff[i]) pos_c = 5'(WORD_W - 1 - i);
      end
      found_c = !(&rd_ff);
      if (is_alloc) new_c = rd_ff | (WORD_W'(32'h8000_0000) >> pos_c);
      else if (mark_ff) new_c = rd_ff | (mask_c & ~excl_c);
      else new_c = rd_ff & ~(mask_c & ~excl_c);
   end

   // memory write port
   always_comb begin
      mem_we = cmd.clear || (cmd.modify && (!is_alloc || found_c));
      mem_wa = cmd.clear ? clr_ff : walk_addr;
      mem_wd = cmd.clear ? '0 : new_c;
   end

   // allocated page address
   always_comb begin
      page_in = page_ff;
      if (cmd.plan) page_in = '0;
      else if (cmd.modify && is_alloc && found_c)
         page_in = {PN_W'(b_ff[cur_ff] + PN_W'({w_ff, pos_c})), {PAGE_SHIFT{1'b0}}};
   end

   // output register
   always_comb begin
      out_failed_in = cmd.out_load ? fail_ff : out_failed_ff;
      out_page_in   = cmd.out_load ? page_ff : out_page_ff;
   end

   // bitmap memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.rd) rd_ff <= mem[walk_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NREG; r++) begin
            base_ff[r]  <= '0;
            pages_ff[r] <= '0;
            kind_ff[r]  <= '0;
         end
         clr_ff <= '0;
      end else begin
         base_ff  <= base_in;
         pages_ff <= pages_in;
         kind_ff  <= kind_in;
         clr_ff   <= clr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      s_pn_ff       <= s_pn_in;
      e_pn_ff       <= e_pn_in;
      aligned_ff    <= aligned_in;
      gt_ff         <= gt_in;
      mark_ff       <= mark_in;
      want_ff       <= want_in;
      b_ff          <= b_in;
      n_ff          <= n_in;
      lo_abs_ff     <= lo_abs_in;
      hi_abs_ff     <= hi_abs_in;
      xlo_abs_ff    <= xlo_abs_in;
      xhi_abs_ff    <= xhi_abs_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      xlo_ff        <= xlo_in;
      xhi_ff        <= xhi_in;
      xv_ff         <= xv_in;
      pend_ff       <= pend_in;
      fail_ff       <= fail_in;
      cur_ff        <= cur_in;
      w_ff          <= w_in;
      page_ff       <= page_in;
      out_failed_ff <= out_failed_in;
      out_page_ff   <= out_page_in;
   end

   // status to the controller
   always_comb begin
      status.clear_last = &clr_ff;
      status.pend_any   = |pend_ff;
      status.last_word  = (w_ff == word_of(hi_ff[cur_ff]));
      status.alloc      = is_alloc;
      status.found      = found_c;
   end

   assign rsp_failed    = out_failed_ff;
   assign rsp_page_addr = out_page_ff;

endmodule

`default_nettype wire

@@ src/page_frame_bitmap_allocator_core.sv @@
// top level of the page frame bitmap allocator
// an item reads each bitmap word it visits, then modifies and writes it back through
// the one bitmap port; a range visits the words it spans in each region, an
// allocation up to pages/32 words per matching region; the result sits in an output
// register, so the next word is accepted while a result waits to be taken
// reset clears the region registers, then sweeps the bitmap to zero one word a cycle
// with req ready low
`timescale 1ns / 1ps
`default_nettype none

module page_frame_bitmap_allocator_core import pfba_pkg::*; #(
   parameter int MAX_PAGES   = 1024,
   parameter int NUM_REGIONS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   pfba_req_if.sink             req_port,
   pfba_rsp_if.source           rsp_port
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // region registers, bitmap and walk
   pfba_dp #(
      .MAX_PAGES   (MAX_PAGES),
      .NUM_REGIONS (NUM_REGIONS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_op        (req_port.op),
      .req_addr      (req_port.addr),
      .req_end_addr  (req_port.end_addr),
      .req_mark_used (req_port.mark_used),
      .req_mem_type  (req_port.mem_type),
      .cmd           (cmd),
      .status        (status),
      .rsp_failed    (rsp_port.failed),
      .rsp_page_addr (rsp_port.page_addr)
   );

endmodule

`default_nettype wire

@@ verif/page_frame_bitmap_allocator_core_test.sv @@
// self-checking testbench of the page frame bitmap allocator core, with its own bitmap model
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_core_test;
   import pfba_pkg::*;

   localparam int MAXPG       = 1024;
   localparam int WPR         = (MAXPG + 31) / 32;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 200;

   typedef struct {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] end_addr;
      logic              mark_used;
      logic [KIND_W-1:0] mem_type;
   } req_word_type;

   typedef struct {
      logic              failed;
      logic [ADDR_W-1:0] page_addr;
   } rsp_word_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;

   pfba_req_if req_ch ();
   pfba_rsp_if rsp_ch ();

   page_frame_bitmap_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch)
   );

   // model state: used-page bitmap and region registers
   logic [31:0]        used_map [NREG*WPR];
   logic [ADDR_W-1:0]  base_cfg [NREG];
   logic [PAGES_W-1:0] pages_cfg [NREG];
   logic [KIND_W-1:0]  kind_cfg [NREG];

   req_word_type request_q [$];
   rsp_word_type pending_outcomes [$];

   int  items_posted = 0;
   int  items_taken = 0;
   int  err_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_arm = 0;
   bit  idle_on = 1;
   bit  req_fire = 0;
   bit  rsp_fire = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("page_frame_bitmap_allocator_core_test NOT OK");
         $finish;
      end
   end

   // page-aligned start of a region, 33 bits wide
   function automatic logic [32:0] region_start(int r);
      return {1'b0, base_cfg[r][31:12], 12'h000};
   endfunction

   // live page count: clamped to the bitmap size and to the top of memory
   function automatic logic [32:0] region_len(int r);
      logic [32:0] n;
      logic [32:0] room;
      n = 33'(pages_cfg[r]);
      room = (33'h1_0000_0000 - region_start(r)) >> 12;
      if (n > 33'(MAXPG)) n = 33'(MAXPG);
      if (n > room) n = room;
      return n;
   endfunction

   // mark or release one page, lowest region wins on overlap
   function automatic logic page_bit_write(logic [ADDR_W-1:0] a, logic used);
      logic [32:0] n;
      logic [32:0] b;
      logic [32:0] idx;
      int pg;
      if (a[11:0] != 12'h000) return 1'b1;
      for (int r = 0; r < NREG; r++) begin
         n = region_len(r);
         b = region_start(r);
         if (n == 0 || {1'b0, a} < b) continue;
         idx = ({1'b0, a} - b) >> 12;
         if (idx < n) begin
            pg = int'(idx);
            used_map[r*WPR + pg/32][31 - pg%32] = used;
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // walk every region page inside [s, e]
   function automatic logic span_write(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e,
                                       logic used);
      logic [32:0] n;
      logic [32:0] b;
      logic [32:0] a;
      if (s > e) return 1'b1;
      if (s[11:0] != 12'h000) return 1'b0;
      for (int r = 0; r < NREG; r++) begin
         n = region_len(r);
         b = region_start(r);
         for (int i = 0; i < int'(n); i++) begin
            a = b + 33'(i) * 33'h1000;
            if (a >= {1'b0, s} && a <= {1'b0, e})
               void'(page_bit_write(a[31:0], used));
         end
      end
      return 1'b0;
   endfunction

   // first free page, msb first, in whole words of the matching regions, lowest region first
   function automatic logic [ADDR_W-1:0] claim_first_free(logic [KIND_W-1:0] kind);
      logic [32:0] n;
      logic [32:0] a;
      int nwords;
      int wi;
      for (int r = 0; r < NREG; r++) begin
         n = region_len(r);
         if (n == 0 || kind_cfg[r] != kind) continue;
         nwords = int'(n) / 32;
         for (int w = 0; w < nwords; w++) begin
            wi = r*WPR + w;
            if (used_map[wi] == 32'hFFFF_FFFF) continue;
            for (int k = 0; k < 32; k++) begin
               if (!used_map[wi][31-k]) begin
                  used_map[wi][31-k] = 1'b1;
                  a = region_start(r) + 33'(w*32 + k) * 33'h1000;
                  return a[31:0];
               end
            end
         end
      end
      return '0;
   endfunction

   // expected result of one request word, updating the model bitmap
   function automatic rsp_word_type apply_request(req_word_type w);
      rsp_word_type o;
      o.failed = 1'b1;
      o.page_addr = '0;
      case (w.op)
         OP_PAGE:  o.failed = page_bit_write(w.addr, w.mark_used);
         OP_RANGE: o.failed = span_write(w.addr, w.end_addr, w.mark_used);
         OP_ALLOC: begin
            o.failed = 1'b0;
            o.page_addr = claim_first_free(w.mem_type);
         end
         default: o.failed = 1'b1;
      endcase
      return o;
   endfunction

   task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (err_count < 10)
         $display("mismatch on %s: expected %h, got %h (cycle %0d)",
                  field, want, got, cycle_count);
      err_count++;
   endtask

   // scoreboard: sample both channels at the rising edge
   always @(posedge clock) begin : scoreboard
      req_word_type w;
      rsp_word_type want;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      rsp_fire = !reset && rsp_ch.valid && rsp_ch.ready;
      if (rsp_fire) begin
         if (pending_outcomes.size() == 0) begin
            if (err_count < 10)
               $display("unexpected result word: failed %b page %h (cycle %0d)",
                        rsp_ch.failed, rsp_ch.page_addr, cycle_count);
            err_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.failed !== want.failed)
               flag_mismatch("failed", 32'(want.failed), 32'(rsp_ch.failed));
            if (rsp_ch.page_addr !== want.page_addr)
               flag_mismatch("page_addr", want.page_addr, rsp_ch.page_addr);
         end
      end
      if (req_fire) begin
         w.op = op_type'(req_ch.op);
         w.addr = req_ch.addr;
         w.end_addr = req_ch.end_addr;
         w.mark_used = req_ch.mark_used;
         w.mem_type = req_ch.mem_type;
         pending_outcomes.push_back(apply_request(w));
         items_taken++;
      end
   end

   // request driver, fed from the request queue
   always @(negedge clock) begin : req_driver
      req_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (request_q.size() != 0) begin
            w = request_q.pop_front();
            req_ch.op <= w.op;
            req_ch.addr <= w.addr;
            req_ch.end_addr <= w.end_addr;
            req_ch.mark_used <= w.mark_used;
            req_ch.mem_type <= w.mem_type;
            req_ch.valid <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 14);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // long receiver hold, counted on its own
   always @(posedge clock) begin : rsp_hold
      if (hold_arm) begin
         hold_left = HOLD_CYCLES;
         hold_arm = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   // result receiver with random stall bursts
   always @(negedge clock) begin : rsp_sink
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0 || stall_left > 0) begin
         if (stall_left > 0) stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic post_request(op_type op, logic [ADDR_W-1:0] addr,
                               logic [ADDR_W-1:0] end_addr, logic used,
                               logic [KIND_W-1:0] kind);
      req_word_type w;
      w.op = op;
      w.addr = addr;
      w.end_addr = end_addr;
      w.mark_used = used;
      w.mem_type = kind;
      request_q.push_back(w);
      items_posted++;
   endtask

   // wait until every word is taken and every result is back
   task automatic wait_drained();
      do @(negedge clock);
      while (items_taken != items_posted || pending_outcomes.size() != 0);
   endtask

   // write all six region registers, block idle
   task automatic load_regions(logic [ADDR_W-1:0] b0, logic [PAGES_W-1:0] p0,
                               logic [KIND_W-1:0] k0, logic [ADDR_W-1:0] b1,
                               logic [PAGES_W-1:0] p1, logic [KIND_W-1:0] k1);
      csr_type     idx [6];
      logic [31:0] val [6];
      idx = '{CSR_BASE0, CSR_PAGES0, CSR_KIND0, CSR_BASE1, CSR_PAGES1, CSR_KIND1};
      val = '{b0, 32'(p0), 32'(k0), b1, 32'(p1), 32'(k1)};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      base_cfg[0] = b0;
      pages_cfg[0] = p0;
      kind_cfg[0] = k0;
      base_cfg[1] = b1;
      pages_cfg[1] = p1;
      kind_cfg[1] = k1;
   endtask

   // random region layout: tops of memory, overlaps, odd and whole-word sizes
   task automatic random_regions();
      logic [ADDR_W-1:0]  b [2];
      logic [PAGES_W-1:0] p [2];
      logic [KIND_W-1:0]  k [2];
      for (int r = 0; r < 2; r++) begin
         case ($urandom_range(0, 3))
            0: b[r] = 32'hFFFF_F000 - (32'($urandom_range(0, 40)) << 12);
            1: b[r] = (r == 1) ? b[0] + (32'($urandom_range(0, 64)) << 12) : 32'h0;
            default: b[r] = $urandom() & 32'hFFFF_F000;
         endcase
         if (b[r] < 32'hFFFF_F000 && $urandom_range(0, 4) == 0)
            b[r] = b[r] | 32'($urandom_range(1, 4095));
         case ($urandom_range(0, 5))
            0: p[r] = '0;
            1: p[r] = 11'd32;
            2: p[r] = 11'd64;
            3: p[r] = 11'd1024;
            default: p[r] = 11'($urandom_range(1, 1024));
         endcase
         k[r] = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 2));
      end
      load_regions(b[0], p[0], k[0], b[1], p[1], k[1]);
   endtask

   // random word, mostly aimed at the configured regions
   function automatic req_word_type make_random_item();
      req_word_type w;
      logic [32:0] b;
      int r;
      int pick;
      int pg;
      pick = $urandom_range(0, 99);
      w.op = (pick < 35) ? OP_ALLOC : (pick < 68) ? OP_PAGE : (pick < 95) ? OP_RANGE : OP_NONE;
      w.addr = $urandom();
      w.end_addr = $urandom();
      w.mark_used = 1'($urandom_range(0, 1));
      w.mem_type = 8'($urandom());
      r = $urandom_range(0, NREG-1);
      if ($urandom_range(0, 4) != 0) begin
         b = region_start(r);
         pg = int'($urandom_range(0, int'(region_len(r)) + 4)) - 2;
         w.addr = b[31:0] + (32'(pg) << 12);
         if ($urandom_range(0, 9) == 0)
            w.addr[11:0] = 12'($urandom());
         w.mem_type = kind_cfg[$urandom_range(0, NREG-1)];
      end
      case ($urandom_range(0, 9))
         0: w.end_addr = 32'hFFFF_FFFF;
         1: w.end_addr = w.addr - 32'($urandom_range(1, 8192));
         2: ;
         default: w.end_addr = w.addr + (32'($urandom_range(0, 40)) << 12)
                               + 32'($urandom_range(0, 1) * 4095);
      endcase
      return w;
   endfunction

   task automatic post_random(int count);
      req_word_type w;
      for (int i = 0; i < count; i++) begin
         w = make_random_item();
         post_request(w.op, w.addr, w.end_addr, w.mark_used, w.mem_type);
      end
   endtask

   // stimulus
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BASE0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.op = OP_NONE;
      req_ch.addr = '0;
      req_ch.end_addr = '0;
      req_ch.mark_used = 1'b0;
      req_ch.mem_type = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < NREG*WPR; i++) used_map[i] = '0;
      for (int r = 0; r < NREG; r++) begin
         base_cfg[r] = '0;
         pages_cfg[r] = '0;
         kind_cfg[r] = '0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // bitmap clearing sweep runs with req ready low
      do @(negedge clock);
      while (!req_ch.ready);

      // directed: region 0 at address zero, region 1 the last page of memory
      load_regions(32'h0, 11'd64, 8'h01, 32'hFFFF_F000, 11'd1024, 8'hFF);
      post_request(OP_ALLOC, 32'h0, 32'h0, 1'b0, 8'h01);               // page zero reads as 0
      post_request(OP_ALLOC, 32'h0, 32'h0, 1'b1, 8'h01);
      post_request(OP_PAGE, 32'h0000_2000, 32'h0, 1'b1, 8'h00);
      post_request(OP_PAGE, 32'h0000_3001, 32'h0, 1'b1, 8'h00);        // misaligned
      post_request(OP_PAGE, 32'h8000_0000, 32'h0, 1'b1, 8'h00);        // unmapped
      post_request(OP_PAGE, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      post_request(OP_PAGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'hFF);
      post_request(OP_RANGE, 32'h0000_5000, 32'h0000_4000, 1'b1, 8'h00); // start past end
      post_request(OP_RANGE, 32'h0000_4001, 32'h0000_8000, 1'b1, 8'h00); // misaligned start
      post_request(OP_RANGE, 32'h0, 32'h0001_F000, 1'b1, 8'h00);
      post_request(OP_ALLOC, 32'h0, 32'h0, 1'b0, 8'h01);
      post_request(OP_RANGE, 32'h0000_1000, 32'h0000_3FFF, 1'b0, 8'h00);
      post_request(OP_ALLOC, 32'h0, 32'h0, 1'b0, 8'h01);
      post_request(OP_RANGE, 32'hFFFF_E000, 32'hFFFF_FFFF, 1'b1, 8'h00); // no wrap at the top
      post_request(OP_RANGE, 32'hFFFF_F000, 32'hFFFF_F000, 1'b0, 8'h00);
      post_request(OP_ALLOC, 32'h0, 32'h0, 1'b0, 8'hFF);               // region under one word
      post_request(OP_ALLOC, 32'h0, 32'h0, 1'b0, 8'h07);               // no such region
      post_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      post_request(OP_RANGE, 32'h0, 32'hFFFF_FFFF, 1'b0, 8'h00);       // release everything
      post_request(OP_RANGE, 32'h0, 32'h0, 1'b1, 8'h00);
      post_request(OP_PAGE, 32'h0, 32'h0, 1'b0, 8'h00);
      post_request(OP_ALLOC, 32'h0, 32'h0, 1'b0, 8'h01);
      wait_drained();

      // overlapping regions of one kind, base with ignored low bits
      load_regions(32'h0004_0000, 11'd40, 8'h03, 32'h0004_5ABC, 11'd1024, 8'h03);
      post_random(150);
      wait_drained();

      // region 0 absent; receiver holds off while words keep coming
      load_regions(32'h1234_5000, 11'd0, 8'h00, 32'h7FFF_0000, 11'd200, 8'h00);
      @(negedge clock);
      hold_arm = 1;
      post_random(250);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         random_regions();
         post_random(250);
         wait_drained();
      end

      // last stretch at full rate: full-size region and one clamped at the top
      idle_on = 0;
      load_regions(32'h0, 11'd1024, 8'h5A, 32'hFFFE_0000, 11'd1024, 8'hA5);
      post_random(300);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (err_count == 0 && pending_outcomes.size() == 0)
         $display("page_frame_bitmap_allocator_core_test OK");
      else
         $display("page_frame_bitmap_allocator_core_test NOT OK");
      $finish;
   end

endmodule

@@ page_frame_bitmap_allocator_core.f @@
src/pfba_pkg.sv
src/pfba_if.sv
src/pfba_ctrl.sv
src/pfba_dp.sv
src/page_frame_bitmap_allocator_core.sv
verif/page_frame_bitmap_allocator_core_test.sv
